>>> hw/rtl/text_string_unescape_assert.svh
// Assertion macros used by the string unescape RTL.
`ifndef TEXT_STRING_UNESCAPE_ASSERT_SVH
`define TEXT_STRING_UNESCAPE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/tsu_pkg.sv
// Types, character codes and decode functions of the string unescape block.
`timescale 1ns / 1ps
`default_nettype none

package tsu_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A_LOW  = 8'h61;
    localparam logic [7:0] CH_F_LOW  = 8'h66;
    localparam logic [7:0] CASE_BIT  = 8'h20;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;

    localparam int unsigned CP_W = 21;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] ACC_LIMIT = CP_MAX / 16;
    localparam logic [CP_W-1:0] LIM_1BYTE = 21'h00007F;
    localparam logic [CP_W-1:0] LIM_2BYTE = 21'h0007FF;
    localparam logic [CP_W-1:0] LIM_3BYTE = 21'h00FFFF;

    localparam int unsigned MAX_OUT = 4;
    localparam int unsigned CNT_W   = 3;

    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_ESC   = 4'b0010,
        MODE_HELD  = 4'b0100,
        MODE_CP    = 4'b1000
    } t_mode;

    typedef logic [MAX_OUT-1:0][7:0] t_bytes;

    // The bytes caused by one input item, first byte in slot 0.
    typedef struct packed {
        t_bytes           bytes;
        logic [CNT_W-1:0] cnt;
        logic             last;
        logic             empty;
    } t_group;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        t_bytes           bytes;
        logic [CNT_W-1:0] cnt;
    } t_utf8;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex       h;
        logic [7:0] lc;
        logic [7:0] d;
        h  = '0;
        lc = c | CASE_BIT;
        if (c inside {[CH_0:CH_9]}) begin
            d     = c - CH_0;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end else if (lc inside {[CH_A_LOW:CH_F_LOW]}) begin
            d     = lc - CH_A_LOW + 8'd10;
            h.ok  = 1'b1;
            h.val = d[3:0];
        end
        return h;
    endfunction

    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] m;
        case (c)
            CH_T:    m = BYTE_TAB;
            CH_N:    m = BYTE_LF;
            CH_R:    m = BYTE_CR;
            default: m = c;
        endcase
        return m;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [CP_W-1:0] cp);
        t_utf8 u;
        u = '0;
        if (cp <= LIM_1BYTE) begin
            u.bytes[0] = cp[7:0];
            u.cnt      = 3'd1;
        end else if (cp <= LIM_2BYTE) begin
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
            u.cnt      = 3'd2;
        end else if (cp <= LIM_3BYTE) begin
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
            u.cnt      = 3'd3;
        end else begin
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
            u.cnt      = 3'd4;
        end
        return u;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tsu_decode.sv
// Escape decoder: mode, held character and code point registers, and the byte group logic.
`timescale 1ns / 1ps
`default_nettype none

module tsu_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_body_end,
    output tsu_pkg::t_group      o_group
);

    tsu_pkg::t_mode                    r_mode, n_mode;
    logic [7:0]                        r_held, n_held;
    logic [tsu_pkg::CP_W-1:0]          r_acc, n_acc;
    logic [tsu_pkg::CP_W-1:0]          acc_upd;
    tsu_pkg::t_hex                     hx_b, hx_h;
    tsu_pkg::t_utf8                    enc;
    tsu_pkg::t_group                   grp;

    assign hx_b = tsu_pkg::hex_value(i_in_byte);
    assign hx_h = tsu_pkg::hex_value(r_held);

    // Digits are only taken while the code point cannot pass the Unicode limit.
    assign acc_upd = (hx_b.ok && r_acc <= tsu_pkg::ACC_LIMIT) ?
                     {r_acc[tsu_pkg::CP_W-5:0], hx_b.val} : r_acc;

    always_comb begin
        enc = tsu_pkg::utf8_encode(acc_upd);
        if (r_mode == tsu_pkg::MODE_CP && i_in_byte == tsu_pkg::CH_RBRACE) begin
            enc = tsu_pkg::utf8_encode(r_acc);
        end else if (r_mode == tsu_pkg::MODE_HELD) begin
            enc = tsu_pkg::utf8_encode('0);
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_held = r_held;
        n_acc  = r_acc;
        grp    = '0;
        case (r_mode)
            tsu_pkg::MODE_PLAIN: begin
                if (i_in_byte == tsu_pkg::CH_BSLASH) begin
                    n_mode = tsu_pkg::MODE_ESC;
                end else begin
                    grp.bytes[0] = i_in_byte;
                    grp.cnt      = 3'd1;
                end
            end
            tsu_pkg::MODE_ESC: begin
                if (i_body_end) begin
                    grp.bytes[0] = tsu_pkg::map_escape(i_in_byte);
                    grp.cnt      = 3'd1;
                    n_mode       = tsu_pkg::MODE_PLAIN;
                end else begin
                    n_held = i_in_byte;
                    n_mode = tsu_pkg::MODE_HELD;
                end
            end
            tsu_pkg::MODE_HELD: begin
                if (hx_h.ok && hx_b.ok) begin
                    grp.bytes[0] = {hx_h.val, hx_b.val};
                    grp.cnt      = 3'd1;
                    n_mode       = tsu_pkg::MODE_PLAIN;
                end else if (r_held == tsu_pkg::CH_U && i_in_byte == tsu_pkg::CH_LBRACE) begin
                    n_acc  = '0;
                    n_mode = tsu_pkg::MODE_CP;
                    if (i_body_end) begin
                        grp.bytes = enc.bytes;
                        grp.cnt   = enc.cnt;
                    end
                end else begin
                    // The held character stands alone; new byte is text or a new escape.
                    grp.bytes[0] = tsu_pkg::map_escape(r_held);
                    grp.cnt      = 3'd1;
                    if (i_in_byte == tsu_pkg::CH_BSLASH) begin
                        n_mode = tsu_pkg::MODE_ESC;
                    end else begin
                        grp.bytes[1] = i_in_byte;
                        grp.cnt      = 3'd2;
                        n_mode       = tsu_pkg::MODE_PLAIN;
                    end
                end
            end
            tsu_pkg::MODE_CP: begin
                if (i_in_byte == tsu_pkg::CH_RBRACE) begin
                    grp.bytes = enc.bytes;
                    grp.cnt   = enc.cnt;
                    n_mode    = tsu_pkg::MODE_PLAIN;
                end else begin
                    n_acc = acc_upd;
                    if (i_body_end) begin
                        grp.bytes = enc.bytes;
                        grp.cnt   = enc.cnt;
                    end
                end
            end
            default: begin
                n_mode = tsu_pkg::MODE_PLAIN;
            end
        endcase
        if (i_body_end) begin
            // A body that ends on nothing still delivers its end as an empty item.
            if (grp.cnt == '0) begin
                grp.bytes = '0;
                grp.cnt   = 3'd1;
                grp.empty = 1'b1;
            end
            grp.last = 1'b1;
            n_mode   = tsu_pkg::MODE_PLAIN;
            n_held   = '0;
            n_acc    = '0;
        end
    end

    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tsu_pkg::MODE_PLAIN;
            r_held <= '0;
            r_acc  <= '0;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_acc  <= n_acc;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tsu_emit.sv
// Result register: holds one group of decoded bytes; one leaves per cycle on i_take.
`timescale 1ns / 1ps
`default_nettype none
`include "text_string_unescape_assert.svh"

module tsu_emit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire tsu_pkg::t_group i_group,
    input  wire logic            i_take,
    output logic                 o_free,
    output logic                 o_valid,
    output logic [7:0]           o_byte,
    output logic                 o_last,
    output logic                 o_empty
);

    tsu_pkg::t_bytes                   r_bytes, n_bytes;
    logic [tsu_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic                              r_last, n_last;
    logic                              r_empty, n_empty;
    logic                              pop;

    assign pop    = i_take && (r_cnt != '0);
    assign o_free = (r_cnt == '0) || (i_take && r_cnt == 3'd1);

    always_comb begin
        n_bytes = r_bytes;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_empty = r_empty;
        if (i_load) begin
            n_bytes = i_group.bytes;
            n_cnt   = i_group.cnt;
            n_last  = i_group.last;
            n_empty = i_group.empty;
        end else if (pop) begin
            n_bytes = {8'h00, r_bytes[tsu_pkg::MAX_OUT-1:1]};
            n_cnt   = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    assign o_valid = (r_cnt != '0);
    assign o_byte  = r_bytes[0];
    assign o_last  = r_last && (r_cnt == 3'd1);
    assign o_empty = r_empty;

    `TSU_ASSERT_SAME(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd4, "byte count above four")
    `TSU_ASSERT_SAME(a_load_free, i_clk, i_rst_n, i_load, o_free, "group loaded over pending bytes")
    `TSU_ASSERT_SAME(a_empty_alone, i_clk, i_rst_n, o_valid && r_empty,
                     r_cnt == 3'd1 && r_last, "empty item not a lone final item")
    `TSU_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, pop && !i_load,
                     r_cnt == $past(r_cnt) - 3'd1, "byte count did not step down")

endmodule

`default_nettype wire

>>> hw/rtl/text_string_unescape.sv
// Top level of the quoted string body unescape block.
// Usage:
//   Input channel (i_valid / o_ready) carries one raw body byte per item, with
//   i_body_end high on the final byte of a body. Output channel (o_valid /
//   i_ready) carries one decoded byte per item; o_out_last marks the final item
//   of a body and o_empty_mark an item that carries only the end of a body.
//   The first byte caused by an input item appears in the cycle after it is
//   accepted. Throughput: one input item per cycle while each item yields at
//   most one byte and i_ready is high; an item that yields more bytes holds
//   the result register until its last byte goes out, and the next item waits.
//   The result register drains one byte per cycle while i_ready is high.
//   o_ready is high whenever the result register is empty or is giving up its
//   last byte in this cycle, so input and output overlap.
//   When the receiver stalls, the pending byte holds and input stalls once the
//   register cannot take a new group. Reset clears the decoder to plain text
//   and drops any pending bytes; the block is ready in the first cycle after.
`timescale 1ns / 1ps
`default_nettype none

module text_string_unescape (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_body_end,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last,
    output logic            o_empty_mark
);

    tsu_pkg::t_group group;
    logic            accept;
    logic            free;

    assign o_ready = free;
    assign accept  = i_valid && free;

    tsu_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (accept),
        .i_in_byte  (i_in_byte),
        .i_body_end (i_body_end),
        .o_group    (group)
    );

    tsu_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && group.cnt != '0),
        .i_group (group),
        .i_take  (i_ready),
        .o_free  (free),
        .o_valid (o_valid),
        .o_byte  (o_out_byte),
        .o_last  (o_out_last),
        .o_empty (o_empty_mark)
    );

endmodule

`default_nettype wire
